@@ design/v3a_pkg.sv @@
// ----------------------------------------------------------------------------
// v3a_pkg
// Shared types, opcodes, status codes and saturation helper for the
// three-component fixed-point vector unit.
// ----------------------------------------------------------------------------
package v3a_pkg;

  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_SCALE = 4'd2,
    OP_MUL   = 4'd3,
    OP_DOT   = 4'd4,
    OP_CROSS = 4'd5,
    OP_MAG   = 4'd6,
    OP_NORM  = 4'd7,
    OP_CMP   = 4'd8,
    OP_NEG   = 4'd9
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef logic signed [31:0] word_t;

  // per-beat data that rides along the sqrt and divide pipes
  typedef struct packed {
    logic       vld;
    op_t        op;
    word_t      rx;
    word_t      ry;
    word_t      rz;
    word_t      scal;
    logic       eq;
    logic [1:0] st;
    word_t      ax;
    word_t      ay;
    word_t      az;
  } tag_t;

  // {overflow, clamped value}
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] res;
    if (v > 64'sd2147483647) begin
      res = {1'b1, 32'h7fff_ffff};
    end else if (v < -64'sd2147483648) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

@@ design/v3a_front.sv @@
// ----------------------------------------------------------------------------
// v3a_front
// Two stages: operand select and six signed multipliers, then truncation,
// sums, saturation and the sum of squares for the sqrt pipe.
// ----------------------------------------------------------------------------
module v3a_front #(
  parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_vld,
  input  logic [3:0]             opcode,
  input  v3a_pkg::word_t         a_x,
  input  v3a_pkg::word_t         a_y,
  input  v3a_pkg::word_t         a_z,
  input  v3a_pkg::word_t         b_x,
  input  v3a_pkg::word_t         b_y,
  input  v3a_pkg::word_t         b_z,
  input  v3a_pkg::word_t         scale_factor,
  output v3a_pkg::tag_t          tag_out,
  output logic [63:0]            sq_out
);

  v3a_pkg::op_t   op_in;
  v3a_pkg::word_t ma [6];
  v3a_pkg::word_t mb [6];
  logic signed [63:0] prod [6];

  logic               s1_vld;
  v3a_pkg::op_t       s1_op;
  v3a_pkg::word_t     s1_a [3];
  v3a_pkg::word_t     s1_b [3];
  logic signed [63:0] s1_p [6];

  assign op_in = v3a_pkg::op_t'(opcode);

  always_comb begin
    ma[0] = a_x; mb[0] = b_x;
    ma[1] = a_y; mb[1] = b_y;
    ma[2] = a_z; mb[2] = b_z;
    ma[3] = a_z; mb[3] = b_y;
    ma[4] = a_x; mb[4] = b_z;
    ma[5] = a_y; mb[5] = b_x;
    case (op_in)
      v3a_pkg::OP_SCALE: begin
        mb[0] = scale_factor; mb[1] = scale_factor; mb[2] = scale_factor;
      end
      v3a_pkg::OP_CROSS: begin
        ma[0] = a_y; mb[0] = b_z;
        ma[1] = a_z; mb[1] = b_x;
        ma[2] = a_x; mb[2] = b_y;
      end
      v3a_pkg::OP_MAG, v3a_pkg::OP_NORM: begin
        mb[0] = a_x; mb[1] = a_y; mb[2] = a_z;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 6; i++) begin
      prod[i] = ma[i] * mb[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= in_vld;
    end
    s1_op   <= op_in;
    s1_a[0] <= a_x; s1_a[1] <= a_y; s1_a[2] <= a_z;
    s1_b[0] <= b_x; s1_b[1] <= b_y; s1_b[2] <= b_z;
    for (int i = 0; i < 6; i++) begin
      s1_p[i] <= prod[i];
    end
  end

  // stage 2
  logic signed [63:0] q  [6];
  logic signed [63:0] xa [3];
  logic signed [63:0] xb [3];
  logic [32:0]        s  [3];
  logic [32:0]        sd;
  logic               eq;
  v3a_pkg::tag_t      tag_next;
  logic [63:0]        sq_next;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      q[i] = s1_p[i] >>> FRAC_BITS;
    end
    for (int i = 0; i < 3; i++) begin
      xa[i] = s1_a[i];
      xb[i] = s1_b[i];
      s[i]  = '0;
    end
    sd = '0;
    eq = 1'b0;
    case (s1_op)
      v3a_pkg::OP_ADD: begin
        for (int i = 0; i < 3; i++) s[i] = v3a_pkg::sat32(xa[i] + xb[i]);
      end
      v3a_pkg::OP_SUB: begin
        for (int i = 0; i < 3; i++) s[i] = v3a_pkg::sat32(xa[i] - xb[i]);
      end
      v3a_pkg::OP_NEG: begin
        for (int i = 0; i < 3; i++) s[i] = v3a_pkg::sat32(-xa[i]);
      end
      v3a_pkg::OP_SCALE, v3a_pkg::OP_MUL: begin
        for (int i = 0; i < 3; i++) s[i] = v3a_pkg::sat32(q[i]);
      end
      v3a_pkg::OP_DOT: begin
        sd = v3a_pkg::sat32(q[0] + q[1] + q[2]);
      end
      v3a_pkg::OP_CROSS: begin
        s[0] = v3a_pkg::sat32(q[0] - q[3]);
        s[1] = v3a_pkg::sat32(q[1] - q[4]);
        s[2] = v3a_pkg::sat32(q[2] - q[5]);
      end
      v3a_pkg::OP_CMP: begin
        eq = (s1_a[0] == s1_b[0]) && (s1_a[1] == s1_b[1]) && (s1_a[2] == s1_b[2]);
      end
      default: begin
      end
    endcase
    tag_next.vld  = s1_vld;
    tag_next.op   = s1_op;
    tag_next.rx   = s[0][31:0];
    tag_next.ry   = s[1][31:0];
    tag_next.rz   = s[2][31:0];
    tag_next.scal = sd[31:0];
    tag_next.eq   = eq;
    tag_next.st   = (s[0][32] | s[1][32] | s[2][32] | sd[32]) ? v3a_pkg::ST_SAT
                                                              : v3a_pkg::ST_OK;
    tag_next.ax   = s1_a[0];
    tag_next.ay   = s1_a[1];
    tag_next.az   = s1_a[2];
    // squares are non-negative and three of them fit in 64 bits
    sq_next = s1_p[0] + s1_p[1] + s1_p[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.vld <= 1'b0;
    end else begin
      tag_out <= tag_next;
    end
    sq_out <= sq_next;
  end

endmodule

@@ design/v3a_sqrt.sv @@
// ----------------------------------------------------------------------------
// v3a_sqrt
// Pipelined 64-bit integer square root, one result bit per stage, 32 stages.
// ----------------------------------------------------------------------------
module v3a_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  v3a_pkg::tag_t  tag_in,
  input  logic [63:0]    sq_in,
  output v3a_pkg::tag_t  tag_out,
  output logic [31:0]    root
);

  localparam int NSTG = 32;

  logic [63:0]   n_q [0:NSTG];
  logic [63:0]   r_q [0:NSTG];
  v3a_pkg::tag_t tg  [0:NSTG];

  assign n_q[0] = sq_in;
  assign r_q[0] = '0;
  assign tg[0]  = tag_in;

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        ge;
    assign trial = r_q[k] + BITV;
    assign ge    = n_q[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        tg[k+1].vld <= 1'b0;
      end else begin
        tg[k+1] <= tg[k];
      end
      n_q[k+1] <= ge ? (n_q[k] - trial) : n_q[k];
      r_q[k+1] <= ge ? ((r_q[k] >> 1) + BITV) : (r_q[k] >> 1);
    end
  end

  assign tag_out = tg[NSTG];
  assign root    = r_q[NSTG][31:0];

endmodule

@@ design/v3a_div.sv @@
// ----------------------------------------------------------------------------
// v3a_div
// Three-lane pipelined restoring divider for normalize: |a| * 2^F / m.
// The quotient never exceeds 2^F, so F+1 stages are enough.
// ----------------------------------------------------------------------------
module v3a_div #(
  parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  v3a_pkg::tag_t  tag_in,
  input  logic [31:0]    m_in,
  output v3a_pkg::tag_t  tag_out,
  output logic [31:0]    m_out,
  output v3a_pkg::word_t qx,
  output v3a_pkg::word_t qy,
  output v3a_pkg::word_t qz
);

  localparam int QB = FRAC_BITS + 1;
  localparam int DW = 32 + FRAC_BITS;

  logic [DW-1:0] rem [0:QB][3];
  logic [QB-1:0] quo [0:QB][3];
  logic [31:0]   m_q [0:QB];
  v3a_pkg::tag_t tg  [0:QB];
  v3a_pkg::word_t av [3];
  v3a_pkg::word_t ao [3];
  v3a_pkg::word_t res [3];

  assign av[0] = tag_in.ax;
  assign av[1] = tag_in.ay;
  assign av[2] = tag_in.az;
  assign m_q[0] = m_in;
  assign tg[0]  = tag_in;

  for (genvar l = 0; l < 3; l++) begin : g_in
    logic [31:0] mag;
    assign mag       = av[l][31] ? (32'd0 - av[l]) : av[l];
    assign rem[0][l] = DW'(mag) << FRAC_BITS;
    assign quo[0][l] = '0;
  end

  for (genvar k = 0; k < QB; k++) begin : g_stg
    localparam int J = QB - 1 - k;
    logic [DW-1:0] dvs;
    logic          ge [3];
    assign dvs = DW'(m_q[k]) << J;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        ge[l] = rem[k][l] >= dvs;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tg[k+1].vld <= 1'b0;
      end else begin
        tg[k+1] <= tg[k];
      end
      m_q[k+1] <= m_q[k];
      for (int l = 0; l < 3; l++) begin
        rem[k+1][l] <= ge[l] ? (rem[k][l] - dvs) : rem[k][l];
        quo[k+1][l] <= {quo[k][l][QB-2:0], ge[l]};
      end
    end
  end

  assign ao[0] = tg[QB].ax;
  assign ao[1] = tg[QB].ay;
  assign ao[2] = tg[QB].az;

  // truncation toward zero: divide magnitudes, then restore the sign
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      res[l] = ao[l][31] ? (32'd0 - 32'(quo[QB][l])) : 32'(quo[QB][l]);
    end
  end

  assign tag_out = tg[QB];
  assign m_out   = m_q[QB];
  assign qx      = res[0];
  assign qy      = res[1];
  assign qz      = res[2];

endmodule

@@ design/vec3_arith_unit.sv @@
// ----------------------------------------------------------------------------
// vec3_arith_unit
// Three-component signed fixed-point vector ALU, fully pipelined.
//
//   channel  | handshake     | payload
//   ---------+---------------+---------------------------------------------
//   command  | start / busy  | opcode, a_x..a_z, b_x..b_z, scale_factor
//   result   | done (strobe) | r_x, r_y, r_z, scalar_result, equal_flag, status
//
// Every opcode passes through the same pipeline: 2 multiply/combine stages,
// 32 square-root stages, FRAC_BITS+1 divide stages and the output register.
// One beat is taken every cycle; busy stays low.
// Synchronous reset clears only the valid bits; no clearing pass is needed.
// Results are shown for one cycle with done high; there is no back pressure.
// ----------------------------------------------------------------------------
module vec3_arith_unit #(
  parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [3:0]          opcode,
  input  logic signed [31:0]  a_x,
  input  logic signed [31:0]  a_y,
  input  logic signed [31:0]  a_z,
  input  logic signed [31:0]  b_x,
  input  logic signed [31:0]  b_y,
  input  logic signed [31:0]  b_z,
  input  logic signed [31:0]  scale_factor,
  output logic                done,
  output logic signed [31:0]  r_x,
  output logic signed [31:0]  r_y,
  output logic signed [31:0]  r_z,
  output logic signed [31:0]  scalar_result,
  output logic                equal_flag,
  output logic [1:0]          status
);

  v3a_pkg::tag_t  f_tag, s_tag, d_tag;
  logic [63:0]    f_sq;
  logic [31:0]    s_root, d_m;
  v3a_pkg::word_t d_qx, d_qy, d_qz;

  assign busy = 1'b0;

  v3a_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_vld       (start),
    .opcode       (opcode),
    .a_x          (a_x),
    .a_y          (a_y),
    .a_z          (a_z),
    .b_x          (b_x),
    .b_y          (b_y),
    .b_z          (b_z),
    .scale_factor (scale_factor),
    .tag_out      (f_tag),
    .sq_out       (f_sq)
  );

  v3a_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (f_tag),
    .sq_in   (f_sq),
    .tag_out (s_tag),
    .root    (s_root)
  );

  v3a_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (s_tag),
    .m_in    (s_root),
    .tag_out (d_tag),
    .m_out   (d_m),
    .qx      (d_qx),
    .qy      (d_qy),
    .qz      (d_qz)
  );

  v3a_pkg::word_t rx_next, ry_next, rz_next, scal_next;
  logic           eq_next;
  logic [1:0]     st_next;

  always_comb begin
    rx_next   = d_tag.rx;
    ry_next   = d_tag.ry;
    rz_next   = d_tag.rz;
    scal_next = d_tag.scal;
    eq_next   = d_tag.eq;
    st_next   = d_tag.st;
    case (d_tag.op)
      v3a_pkg::OP_MAG: begin
        // root above the signed maximum clamps
        scal_next = d_m[31] ? 32'h7fff_ffff : d_m;
        st_next   = d_m[31] ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
      end
      v3a_pkg::OP_NORM: begin
        if (d_m == 32'd0) begin
          rx_next = '0;
          ry_next = '0;
          rz_next = '0;
          st_next = v3a_pkg::ST_ZERO;
        end else begin
          rx_next = d_qx;
          ry_next = d_qy;
          rz_next = d_qz;
          st_next = v3a_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_tag.vld;
    end
    r_x           <= rx_next;
    r_y           <= ry_next;
    r_z           <= rz_next;
    scalar_result <= scal_next;
    equal_flag    <= eq_next;
    status        <= st_next;
  end

endmodule
